### design/rhtc_pkg.sv
// Shared types and constants for the ramped heading turn control unit.
// No dependencies; every other design file except rhtc_checker imports this package.
`default_nettype none

package rhtc_pkg;

    // Angles in centidegrees, drive in hundredths of a percent
    localparam int unsigned FULL_TURN   = 36000;
    localparam int unsigned HALF_TURN   = 18000;
    localparam int unsigned DRIVE_LIMIT = 10000;

    localparam int unsigned TICK_MS_DEFAULT = 20;

    // Register reset values
    localparam logic [15:0] RAMP_UP_RESET   = 16'd128;
    localparam logic [15:0] RAMP_DOWN_RESET = 16'd128;
    localparam logic [13:0] MAX_OUT_RESET   = 14'd7000;
    localparam logic [13:0] MIN_OUT_RESET   = 14'd1000;
    localparam logic [14:0] DEADBAND_RESET  = 15'd100;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RAMP_UP   = 3'd0,
        REG_RAMP_DOWN = 3'd1,
        REG_MAX_OUT   = 3'd2,
        REG_MIN_OUT   = 3'd3,
        REG_DEADBAND  = 3'd4
    } reg_index_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [15:0] ramp_up_gain;
        logic [15:0] ramp_down_gain;
        logic [13:0] max_output;
        logic [13:0] min_output;
        logic [14:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] heading_sample;
        logic [15:0] target_heading;
        logic [15:0] timeout_ms;
    } item_t;

    typedef struct packed {
        logic signed [14:0] right_drive;
        logic signed [14:0] left_drive;
        logic               finished;
        logic signed [15:0] heading_error;
    } result_t;

endpackage

`default_nettype wire

### design/ramped_heading_turn_control_unit.sv
// Ramped heading turn controller, top level.
// Path from input transfer to result valid: input register, then the
// arithmetic into the result register. Throughput: one item per cycle while
// m_tready accepts results, set by the single pass through the drive arithmetic.
// Reset: asynchronous, active low; registers return to defaults, turn idle.
`default_nettype none

module ramped_heading_turn_control_unit #(
    parameter int unsigned TICK_MS = rhtc_pkg::TICK_MS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [15:0] heading_sample, [31:16] target_heading, [47:32] timeout_ms
    input  wire logic [47:0]                      s_tdata,
    // [0] operation
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [14:0] right_drive, [29:15] left_drive, [45:30] heading_error, [47:46] zero
    output logic [47:0]                           m_tdata,
    // [0] finished
    output logic                                  m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rhtc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rhtc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rhtc_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    take;
    result_t res;

    assign in_item.operation      = s_tuser;
    assign in_item.heading_sample = s_tdata[15:0];
    assign in_item.target_heading = s_tdata[31:16];
    assign in_item.timeout_ms     = s_tdata[47:32];

    rhtc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rhtc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rhtc_core #(
        .TICK_MS (TICK_MS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (held_valid),
        .item       (held_item),
        .take       (take),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.heading_error, res.left_drive, res.right_drive};
    assign m_tuser = res.finished;

endmodule

`default_nettype wire

### design/rhtc_cfg_regs.sv
// Configuration register file for the ramped heading turn control unit.
// Depends on rhtc_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module rhtc_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rhtc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rhtc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rhtc_pkg::cfg_t                        cfg
);
    import rhtc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_RAMP_UP:   cfg_next.ramp_up_gain   = cfg_data;
                REG_RAMP_DOWN: cfg_next.ramp_down_gain = cfg_data;
                REG_MAX_OUT:   cfg_next.max_output     = cfg_data[13:0];
                REG_MIN_OUT:   cfg_next.min_output     = cfg_data[13:0];
                REG_DEADBAND:  cfg_next.deadband       = cfg_data[14:0];
                default:       cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_up_gain   <= RAMP_UP_RESET;
            cfg_reg.ramp_down_gain <= RAMP_DOWN_RESET;
            cfg_reg.max_output     <= MAX_OUT_RESET;
            cfg_reg.min_output     <= MIN_OUT_RESET;
            cfg_reg.deadband       <= DEADBAND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### design/rhtc_in_stage.sv
// Input register stage: captures one item per transfer and holds it until
// the core takes it. Depends on rhtc_pkg for item_t.
`default_nettype none

module rhtc_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rhtc_pkg::item_t in_item,
    input  wire logic            take,
    output logic                 held_valid,
    output rhtc_pkg::item_t      held_item
);
    import rhtc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

### design/rhtc_core.sv
// Turn state, drive magnitude arithmetic and result register.
// Depends on rhtc_pkg for cfg_t, item_t, result_t and angle constants.
`default_nettype none

module rhtc_core #(
    parameter int unsigned TICK_MS = rhtc_pkg::TICK_MS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rhtc_pkg::cfg_t  cfg,
    input  wire logic            item_valid,
    input  wire rhtc_pkg::item_t item,
    output logic                 take,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output rhtc_pkg::result_t    res
);
    import rhtc_pkg::*;

    // Elapsed time saturates just above any 16-bit time limit.
    localparam int unsigned ELAPSED_W   = 17;
    localparam int unsigned ELAPSED_SAT = 65536;
    // Ramp time in units of 1/100 ms; beyond this the start ramp exceeds
    // every possible max_output for any nonzero gain.
    localparam int unsigned RAMP_W      = 23;
    localparam int unsigned RAMP_SAT    = 1 << (RAMP_W - 1);
    localparam int unsigned RAMP_STEP   = TICK_MS * 100;
    localparam int unsigned RAMP_INIT   = (RAMP_STEP < RAMP_SAT) ? RAMP_STEP : RAMP_SAT;

    function automatic logic [15:0] reduce_heading(input logic [15:0] h);
        logic [15:0] r;
        r = (h >= 16'(FULL_TURN)) ? h - 16'(FULL_TURN) : h;
        return r;
    endfunction

    logic                  running_reg,  running_next;
    logic signed [15:0]    err_reg,      err_next;
    logic [15:0]           goal_reg,     goal_next;
    logic [15:0]           limit_reg,    limit_next;
    logic [ELAPSED_W-1:0]  elapsed_reg,  elapsed_next;
    logic [RAMP_W-1:0]     ramp_reg,     ramp_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               res_reg,      res_next;

    logic [15:0]           goal_sel;
    logic [15:0]           meas_mod;
    logic [15:0]           goal_mod;
    logic signed [16:0]    diff;
    logic signed [16:0]    diff_wrapped;
    logic [15:0]           err_abs;
    logic [14:0]           err_mag;
    logic                  drive_on;
    logic [38:0]           start_prod;
    logic [30:0]           start_line;
    logic [30:0]           end_prod;
    logic [22:0]           end_line;
    logic [13:0]           m_ceil;
    logic [13:0]           m_end;
    logic [13:0]           m_floor;
    logic [13:0]           mag;
    logic signed [14:0]    right;
    logic [ELAPSED_W:0]    elapsed_sum;
    logic [RAMP_W:0]       ramp_sum;

    assign take      = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Wrapped error of the incoming sample against the goal in force
    always_comb
    begin
        goal_sel = (item.operation == OP_START) ? item.target_heading : goal_reg;
        meas_mod = reduce_heading(item.heading_sample);
        goal_mod = reduce_heading(goal_sel);
        diff     = $signed({1'b0, meas_mod}) - $signed({1'b0, goal_mod});
        if (diff > $signed(17'(HALF_TURN)))
        begin
            diff_wrapped = diff - $signed(17'(FULL_TURN));
        end
        else if (diff < -$signed(17'(HALF_TURN)))
        begin
            diff_wrapped = diff + $signed(17'(FULL_TURN));
        end
        else
        begin
            diff_wrapped = diff;
        end
    end

    // Drive magnitude from the stored error and ramp time
    always_comb
    begin
        err_abs    = err_reg[15] ? 16'(-err_reg) : 16'(err_reg);
        err_mag    = err_abs[14:0];
        drive_on   = running_reg && (err_mag > cfg.deadband)
                     && (elapsed_reg < {1'b0, limit_reg});
        start_prod = 39'(cfg.ramp_up_gain) * 39'(ramp_reg);
        start_line = start_prod[38:8];
        end_prod   = 31'(cfg.ramp_down_gain) * 31'(err_mag);
        end_line   = end_prod[30:8];
        m_ceil     = (start_line < 31'(cfg.max_output)) ? start_line[13:0] : cfg.max_output;
        m_end      = (23'(m_ceil) > end_line) ? end_line[13:0] : m_ceil;
        m_floor    = (m_end < cfg.min_output) ? cfg.min_output : m_end;
        mag        = (m_floor > 14'(DRIVE_LIMIT)) ? 14'(DRIVE_LIMIT) : m_floor;
        right      = err_reg[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(TICK_MS);
        ramp_sum    = {1'b0, ramp_reg} + (RAMP_W+1)'(RAMP_STEP);

        running_next   = running_reg;
        err_next       = err_reg;
        goal_next      = goal_reg;
        limit_next     = limit_reg;
        elapsed_next   = elapsed_reg;
        ramp_next      = ramp_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res_ready;

        if (take)
        begin
            out_valid_next = 1'b1;
            if (item.operation == OP_START)
            begin
                goal_next    = item.target_heading;
                limit_next   = item.timeout_ms;
                elapsed_next = '0;
                ramp_next    = RAMP_W'(RAMP_INIT);
                err_next     = diff_wrapped[15:0];
                running_next = 1'b1;
                res_next.right_drive   = '0;
                res_next.left_drive    = '0;
                res_next.finished      = 1'b0;
                res_next.heading_error = diff_wrapped[15:0];
            end
            else if (drive_on)
            begin
                err_next     = diff_wrapped[15:0];
                elapsed_next = (elapsed_sum >= (ELAPSED_W+1)'(ELAPSED_SAT))
                               ? ELAPSED_W'(ELAPSED_SAT) : elapsed_sum[ELAPSED_W-1:0];
                ramp_next    = (ramp_sum >= (RAMP_W+1)'(RAMP_SAT))
                               ? RAMP_W'(RAMP_SAT) : ramp_sum[RAMP_W-1:0];
                res_next.right_drive   = right;
                res_next.left_drive    = -right;
                res_next.finished      = 1'b0;
                res_next.heading_error = diff_wrapped[15:0];
            end
            else
            begin
                running_next = 1'b0;
                res_next.right_drive   = '0;
                res_next.left_drive    = '0;
                res_next.finished      = 1'b1;
                res_next.heading_error = err_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            err_reg       <= '0;
            goal_reg      <= '0;
            limit_reg     <= '0;
            elapsed_reg   <= '0;
            ramp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            err_reg       <= err_next;
            goal_reg      <= goal_next;
            limit_reg     <= limit_next;
            elapsed_reg   <= elapsed_next;
            ramp_reg      <= ramp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

### design/rhtc_checker.sv
// Port-level checks for the ramped heading turn control unit, bound to the
// top level. Depends only on the top-level port list.
`default_nettype none

module rhtc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);
    logic signed [14:0] right;
    logic signed [14:0] left;
    logic signed [15:0] err;

    assign right = $signed(m_tdata[14:0]);
    assign left  = $signed(m_tdata[29:15]);
    assign err   = $signed(m_tdata[45:30]);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (right == 15'sd0) && (left == 15'sd0))
        else $error("finished result with nonzero drive");

    a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (right + left) == 15'sd0)
        else $error("wheel drives are not opposite");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (right <= 15'sd10000) && (right >= -15'sd10000)
                     && (err <= 16'sd18000) && (err >= -16'sd18000))
        else $error("drive or heading error out of range");

endmodule

bind ramped_heading_turn_control_unit rhtc_checker u_rhtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
